FILE: hdl/bis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants of the burner ignition sequencer.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int unsigned PhaseW  = 4;
  localparam int unsigned TimerW  = 16;
  localparam int unsigned TrialW  = 8;
  localparam int unsigned ValveW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned BlinkW  = 9;

  // phase codes
  localparam logic [PhaseW-1:0] PH_IDLE     = 4'd0;
  localparam logic [PhaseW-1:0] PH_PREPURGE = 4'd1;
  localparam logic [PhaseW-1:0] PH_IGNITE   = 4'd2;
  localparam logic [PhaseW-1:0] PH_PROVE    = 4'd3;
  localparam logic [PhaseW-1:0] PH_MAIN     = 4'd4;
  localparam logic [PhaseW-1:0] PH_SHUTDOWN = 4'd5;
  localparam logic [PhaseW-1:0] PH_LOCKOUT  = 4'd6;
  localparam logic [PhaseW-1:0] PH_RETRY    = 4'd7;
  localparam logic [PhaseW-1:0] PH_CONFIRM  = 4'd8;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_PREPURGE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TRIAL    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PROVE    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MAXTRIAL = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RETRY    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SHUTDOWN = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_CONFIRM  = 3'd6;

  // register reset values
  localparam logic [TimerW-1:0] PREPURGE_RST = 16'd3000;
  localparam logic [TimerW-1:0] TRIAL_RST    = 16'd10000;
  localparam logic [TimerW-1:0] PROVE_RST    = 16'd1000;
  localparam logic [TrialW-1:0] MAXTRIAL_RST = 8'd3;
  localparam logic [TimerW-1:0] RETRY_RST    = 16'd5000;
  localparam logic [TimerW-1:0] SHUTDOWN_RST = 16'd1000;
  localparam logic [TimerW-1:0] CONFIRM_RST  = 16'd1000;

  // lockout blink
  localparam logic [BlinkW-1:0] BLINK_LAST = 9'd499;
  localparam logic [BlinkW-1:0] BLINK_ON   = 9'd250;

  localparam logic [TrialW-1:0] TRIAL_MAX = 8'hFF;

  typedef struct packed {
    logic [TimerW-1:0] prepurge_ticks;
    logic [TimerW-1:0] ignition_trial_ticks;
    logic [TimerW-1:0] prove_ticks;
    logic [TrialW-1:0] trial_limit;
    logic [TimerW-1:0] retry_wait_ticks;
    logic [TimerW-1:0] shutdown_ticks;
    logic [TimerW-1:0] reset_confirm_ticks;
  } bis_cfg_t;

endpackage

FILE: hdl/bis_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_cfg
// Timing and trial limit registers, written through a plain write port.
// ----------------------------------------------------------------------------
module bis_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        we_i,
  input  logic [bis_pkg::CfgIdxW-1:0] idx_i,
  input  logic [bis_pkg::CfgDatW-1:0] wdata_i,
  output bis_pkg::bis_cfg_t           cfg_o
);

  bis_pkg::bis_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prepurge_ticks       <= bis_pkg::PREPURGE_RST;
      cfg_q.ignition_trial_ticks <= bis_pkg::TRIAL_RST;
      cfg_q.prove_ticks          <= bis_pkg::PROVE_RST;
      cfg_q.trial_limit          <= bis_pkg::MAXTRIAL_RST;
      cfg_q.retry_wait_ticks     <= bis_pkg::RETRY_RST;
      cfg_q.shutdown_ticks       <= bis_pkg::SHUTDOWN_RST;
      cfg_q.reset_confirm_ticks  <= bis_pkg::CONFIRM_RST;
    end else if (we_i) begin
      unique case (idx_i)
        bis_pkg::REG_PREPURGE: cfg_q.prepurge_ticks       <= wdata_i;
        bis_pkg::REG_TRIAL:    cfg_q.ignition_trial_ticks <= wdata_i;
        bis_pkg::REG_PROVE:    cfg_q.prove_ticks          <= wdata_i;
        bis_pkg::REG_MAXTRIAL: cfg_q.trial_limit          <= wdata_i[bis_pkg::TrialW-1:0];
        bis_pkg::REG_RETRY:    cfg_q.retry_wait_ticks     <= wdata_i;
        bis_pkg::REG_SHUTDOWN: cfg_q.shutdown_ticks       <= wdata_i;
        bis_pkg::REG_CONFIRM:  cfg_q.reset_confirm_ticks  <= wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/burner_ignition_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burner_ignition_sequencer_top
// Gas valve ignition sequencer, advanced by one tick per input transfer.
//
//   channel | direction | handshake             | payload
//   in      | sink      | in_valid_i/in_stall_o | heat, safety, flame, setpoint
//   out     | source    | out_valid_o/out_stall_i | phase, valves, leds
//   cfg     | sink      | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// one tick per cycle unless stalled; result shows the cycle after transfer
// the sequencer state registers double as the output register
// a new transfer is taken whenever the output is empty or being taken
// reset puts the sequencer in idle with green on and loads default timings
// ----------------------------------------------------------------------------
module burner_ignition_sequencer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bis_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bis_pkg::CfgDatW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        heat_request_i,
  input  logic                        safety_active_i,
  input  logic                        flame_present_i,
  input  logic [7:0]                  flow_setpoint_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [3:0]                  phase_o,
  output logic                        pilot_valve_o,
  output logic                        igniter_on_o,
  output logic                        main_enabled_o,
  output logic [7:0]                  valve_position_o,
  output logic                        green_led_o,
  output logic                        red_led_o
);

  bis_pkg::bis_cfg_t cfg;

  bis_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  logic [bis_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [bis_pkg::TimerW-1:0] timer_q, timer_d;
  logic [bis_pkg::BlinkW-1:0] blink_q, blink_d;
  logic [bis_pkg::TrialW-1:0] trial_q, trial_d;
  logic                       pilot_q, pilot_d;
  logic                       ign_q, ign_d;
  logic                       main_q, main_d;
  logic [bis_pkg::ValveW-1:0] valve_q, valve_d;
  logic                       green_q, green_d;
  logic                       red_q, red_d;
  logic                       out_valid_q;
  logic                       in_acc;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    phase_d = phase_q;
    trial_d = trial_q;
    pilot_d = pilot_q;
    ign_d   = ign_q;
    main_d  = main_q;
    valve_d = valve_q;
    green_d = green_q;
    red_d   = red_q;
    unique case (phase_q)
      bis_pkg::PH_PREPURGE: begin
        if (timer_q >= cfg.prepurge_ticks) phase_d = bis_pkg::PH_IGNITE;
      end
      bis_pkg::PH_IGNITE: begin
        // entry actions on the first tick
        if (timer_q == '0) begin
          pilot_d = 1'b1;
          ign_d   = 1'b1;
          if (trial_q != bis_pkg::TRIAL_MAX) trial_d = trial_q + 1'b1;
        end
        if (flame_present_i) begin
          ign_d   = 1'b0;
          phase_d = bis_pkg::PH_PROVE;
        end else if (timer_q >= cfg.ignition_trial_ticks) begin
          ign_d   = 1'b0;
          pilot_d = 1'b0;
          phase_d = (trial_d >= cfg.trial_limit) ? bis_pkg::PH_LOCKOUT : bis_pkg::PH_RETRY;
        end
      end
      bis_pkg::PH_PROVE: begin
        if (!flame_present_i) begin
          phase_d = bis_pkg::PH_SHUTDOWN;
        end else if (timer_q >= cfg.prove_ticks) begin
          phase_d = bis_pkg::PH_MAIN;
          main_d  = 1'b1;
          valve_d = flow_setpoint_i;
          green_d = 1'b1;
          red_d   = 1'b1;
        end
      end
      bis_pkg::PH_MAIN: begin
        valve_d = flow_setpoint_i;
        if (!flame_present_i || !heat_request_i) phase_d = bis_pkg::PH_SHUTDOWN;
      end
      bis_pkg::PH_SHUTDOWN: begin
        main_d  = 1'b0;
        valve_d = '0;
        ign_d   = 1'b0;
        if (timer_q >= cfg.shutdown_ticks) begin
          pilot_d = 1'b0;
          phase_d = bis_pkg::PH_IDLE;
          green_d = 1'b1;
          red_d   = 1'b0;
        end
      end
      bis_pkg::PH_LOCKOUT: begin
        main_d  = 1'b0;
        valve_d = '0;
        ign_d   = 1'b0;
        pilot_d = 1'b0;
        green_d = 1'b0;
        red_d   = (blink_q < bis_pkg::BLINK_ON);
        if (heat_request_i && safety_active_i) phase_d = bis_pkg::PH_CONFIRM;
      end
      bis_pkg::PH_RETRY: begin
        if (timer_q >= cfg.retry_wait_ticks) phase_d = bis_pkg::PH_PREPURGE;
      end
      bis_pkg::PH_CONFIRM: begin
        if (timer_q >= cfg.reset_confirm_ticks) begin
          if (heat_request_i && safety_active_i) begin
            phase_d = bis_pkg::PH_IDLE;
            green_d = 1'b1;
            red_d   = 1'b0;
          end else begin
            phase_d = bis_pkg::PH_LOCKOUT;
          end
        end
      end
      default: begin
        if (heat_request_i) begin
          phase_d = bis_pkg::PH_PREPURGE;
          trial_d = '0;
          green_d = 1'b0;
          red_d   = 1'b1;
        end
      end
    endcase

    // safety switch override
    if (safety_active_i && phase_d != bis_pkg::PH_IDLE && phase_d != bis_pkg::PH_LOCKOUT
        && phase_d != bis_pkg::PH_CONFIRM && phase_d != bis_pkg::PH_SHUTDOWN) begin
      phase_d = bis_pkg::PH_SHUTDOWN;
      main_d  = 1'b0;
      valve_d = '0;
      ign_d   = 1'b0;
    end

    // blink tracks timer mod 500, including the 16-bit wrap
    if (phase_d != phase_q) begin
      timer_d = '0;
      blink_d = '0;
    end else begin
      timer_d = timer_q + 1'b1;
      blink_d = (timer_q == '1 || blink_q == bis_pkg::BLINK_LAST) ? '0 : blink_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bis_pkg::PH_IDLE;
      timer_q <= '0;
      blink_q <= '0;
      trial_q <= '0;
      pilot_q <= 1'b0;
      ign_q   <= 1'b0;
      main_q  <= 1'b0;
      valve_q <= '0;
      green_q <= 1'b1;
      red_q   <= 1'b0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      blink_q <= blink_d;
      trial_q <= trial_d;
      pilot_q <= pilot_d;
      ign_q   <= ign_d;
      main_q  <= main_d;
      valve_q <= valve_d;
      green_q <= green_d;
      red_q   <= red_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign phase_o          = phase_q;
  assign pilot_valve_o    = pilot_q;
  assign igniter_on_o     = ign_q;
  assign main_enabled_o   = main_q;
  assign valve_position_o = valve_q;
  assign green_led_o      = green_q;
  assign red_led_o        = red_q;

  a_timer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_d != phase_q) |=> (timer_q == '0))
    else $error("timer not cleared on phase change");

  a_blink_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blink_q <= bis_pkg::BLINK_LAST)
    else $error("blink counter out of range");

  a_lockout_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == bis_pkg::PH_LOCKOUT) |-> (!main_q && valve_q == '0))
    else $error("main valve open in lockout");

  a_trial_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(trial_q) && $stable(phase_q))
    else $error("state changed without a transfer");

endmodule
